// ===== src/bssc_pkg.sv =====
// Shared types and constants for the BLDC six-step startup controller.
package bssc_pkg;

  // Fixed tuning constants of the startup sequence.
  localparam int PWM_MAX    = 1023;
  localparam int MIN_SPEED  = 1000;
  localparam int RAMP_STEP  = 50;
  localparam int START_RPM  = 200;
  localparam int RPM_WINDOW = 250;

  // Request types.
  localparam logic [3:0] REQ_START   = 4'd0;
  localparam logic [3:0] REQ_STOP    = 4'd1;
  localparam logic [3:0] REQ_PWM     = 4'd2;
  localparam logic [3:0] REQ_SYSTICK = 4'd3;
  localparam logic [3:0] REQ_CURRENT = 4'd4;
  localparam logic [3:0] REQ_TEMP    = 4'd5;
  localparam logic [3:0] REQ_VBUS    = 4'd6;
  localparam logic [3:0] REQ_BREAK   = 4'd7;
  localparam logic [3:0] REQ_SPEED   = 4'd8;

  // ADC request codes.
  localparam logic [2:0] ADC_NONE = 3'd0;
  localparam logic [2:0] ADC_VBUS = 3'd1;
  localparam logic [2:0] ADC_TEMP = 3'd2;
  localparam logic [2:0] ADC_CUR3 = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] CFG_STARTUP_DUTY = 3'd0;
  localparam logic [2:0] CFG_TRIP_CURRENT = 3'd1;
  localparam logic [2:0] CFG_TRIP_TEMP    = 3'd2;
  localparam logic [2:0] CFG_MIN_CURRENT  = 3'd3;
  localparam logic [2:0] CFG_MAX_CURRENT  = 3'd4;
  localparam logic [2:0] CFG_DUTY_GAIN    = 3'd5;
  localparam logic [2:0] CFG_POLE_PAIRS   = 3'd6;
  localparam logic [2:0] CFG_REVS_RAMP    = 3'd7;

  localparam logic [9:0] STARTUP_DUTY_RST = 10'd200;

  // Configuration register contents.
  typedef struct packed {
    logic [9:0]  startup_duty;
    logic [18:0] trip_current_ma;
    logic [7:0]  trip_temp_c;
    logic [18:0] min_start_current_ma;
    logic [18:0] max_start_current_ma;
    logic [9:0]  duty_gain;
    logic [7:0]  pole_pairs;
    logic [7:0]  revs_per_ramp;
  } cfg_t;

  // One request.
  typedef struct packed {
    logic [3:0]         req_type;
    logic               center_flag;
    logic signed [19:0] sample_value;
  } req_t;

  // One result.
  typedef struct packed {
    logic [1:0]  run_mode;
    logic [2:0]  commutation_step;
    logic [1:0]  driven_phase;
    logic [2:0]  leg_enable_mask;
    logic [9:0]  duty;
    logic [1:0]  sense_leg;
    logic [2:0]  adc_request;
    logic [3:0]  fault_flags;
    logic [15:0] measured_rpm;
    logic [15:0] ramp_rpm;
    logic        freewheel;
  } res_t;

endpackage

// ===== src/bssc_req_if.sv =====
// Request channel interface.
interface bssc_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         req_type;
  logic               center_flag;
  logic signed [19:0] sample_value;

  modport source (output valid, output req_type, output center_flag,
                  output sample_value, input ready);
  modport sink (input valid, input req_type, input center_flag,
                input sample_value, output ready);
endinterface

// ===== src/bssc_res_if.sv =====
// Result channel interface.
interface bssc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  run_mode;
  logic [2:0]  commutation_step;
  logic [1:0]  driven_phase;
  logic [2:0]  leg_enable_mask;
  logic [9:0]  duty;
  logic [1:0]  sense_leg;
  logic [2:0]  adc_request;
  logic [3:0]  fault_flags;
  logic [15:0] measured_rpm;
  logic [15:0] ramp_rpm;
  logic        freewheel;

  modport source (output valid, output run_mode, output commutation_step,
                  output driven_phase, output leg_enable_mask, output duty,
                  output sense_leg, output adc_request, output fault_flags,
                  output measured_rpm, output ramp_rpm, output freewheel,
                  input ready);
  modport sink (input valid, input run_mode, input commutation_step,
                input driven_phase, input leg_enable_mask, input duty,
                input sense_leg, input adc_request, input fault_flags,
                input measured_rpm, input ramp_rpm, input freewheel,
                output ready);
endinterface

// ===== src/bssc_cfg.sv =====
// Configuration register file of the startup controller.
module bssc_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [2:0]       cfg_index,
  input  logic [18:0]      cfg_data,
  output bssc_pkg::cfg_t   cfg
);

  // Register writes, one register per write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.startup_duty         <= bssc_pkg::STARTUP_DUTY_RST;
      cfg.trip_current_ma      <= 19'd20000;
      cfg.trip_temp_c          <= 8'd90;
      cfg.min_start_current_ma <= 19'd500;
      cfg.max_start_current_ma <= 19'd5000;
      cfg.duty_gain            <= 10'd10;
      cfg.pole_pairs           <= 8'd7;
      cfg.revs_per_ramp        <= 8'd4;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        bssc_pkg::CFG_STARTUP_DUTY: cfg.startup_duty <= cfg_data[9:0];
        bssc_pkg::CFG_TRIP_CURRENT: cfg.trip_current_ma <= cfg_data;
        bssc_pkg::CFG_TRIP_TEMP:    cfg.trip_temp_c <= cfg_data[7:0];
        bssc_pkg::CFG_MIN_CURRENT:  cfg.min_start_current_ma <= cfg_data;
        bssc_pkg::CFG_MAX_CURRENT:  cfg.max_start_current_ma <= cfg_data;
        bssc_pkg::CFG_DUTY_GAIN:    cfg.duty_gain <= cfg_data[9:0];
        bssc_pkg::CFG_POLE_PAIRS:   cfg.pole_pairs <= cfg_data[7:0];
        bssc_pkg::CFG_REVS_RAMP:    cfg.revs_per_ramp <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/bssc_core.sv =====
// Motor control state and its combinational update for one request.
module bssc_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  bssc_pkg::cfg_t  cfg,
  input  bssc_pkg::req_t  req,
  output bssc_pkg::res_t  res
);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_OPEN   = 3'b010,
    MODE_CLOSED = 3'b100
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  step;
    logic [9:0]  duty;
    logic        speed_neg;
    logic [2:0]  adc_slot;
    logic [7:0]  pole_tally;
    logic [15:0] rev_tally;
    logic [7:0]  ramp_tally;
    logic [7:0]  window_tally;
    logic [15:0] rpm;
    logic [15:0] ramp_target;
    logic [3:0]  fault;
    logic [1:0]  sense_leg;
  } state_t;

  // Reset state; the fault register is cleared only by rst.
  function automatic state_t cleared(input logic [9:0] duty, input logic [3:0] fault);
    state_t c;
    c.mode         = MODE_IDLE;
    c.step         = 3'd1;
    c.duty         = duty;
    c.speed_neg    = 1'b0;
    c.adc_slot     = 3'd0;
    c.pole_tally   = 8'd0;
    c.rev_tally    = 16'd0;
    c.ramp_tally   = 8'd0;
    c.window_tally = 8'd0;
    c.rpm          = 16'd0;
    c.ramp_target  = 16'(bssc_pkg::START_RPM);
    c.fault        = fault;
    c.sense_leg    = 2'd0;
    return c;
  endfunction

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] c;
    unique case (m)
      MODE_OPEN:   c = 2'd1;
      MODE_CLOSED: c = 2'd2;
      default:     c = 2'd0;
    endcase
    return c;
  endfunction

  // Six-step tables: driven phase, enabled legs and sense leg per step.
  function automatic logic [1:0] phase_of(input logic [2:0] s);
    logic [1:0] p;
    case (s)
      3'd1, 3'd2: p = 2'd1;
      3'd3, 3'd4: p = 2'd2;
      3'd5, 3'd6: p = 2'd3;
      default:    p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] mask_of(input logic [2:0] s);
    logic [2:0] m;
    case (s)
      3'd1, 3'd4: m = 3'd3;
      3'd2, 3'd5: m = 3'd5;
      3'd3, 3'd6: m = 3'd6;
      default:    m = 3'd0;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] sense_of(input logic [2:0] s);
    logic [1:0] l;
    case (s)
      3'd1, 3'd6: l = 2'd2;
      3'd2, 3'd3: l = 2'd3;
      3'd4, 3'd5: l = 2'd1;
      default:    l = 2'd0;
    endcase
    return l;
  endfunction

  state_t      st;
  state_t      st_next;
  logic        stop;
  logic [3:0]  fault_set;
  logic [2:0]  adc;
  logic        fw;
  logic [19:0] mag;
  logic [7:0]  temp;
  logic [10:0] duty_sum;
  logic [7:0]  ramp_inc;
  logic [16:0] ramp_sum;

  // State register, updated when a request completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= cleared(bssc_pkg::STARTUP_DUTY_RST, 4'd0);
    end else if (en) begin
      st <= st_next;
    end
  end

  // Sample magnitude, saturated temperature and partial sums.
  always_comb begin
    mag      = req.sample_value[19] ? (~req.sample_value + 20'd1) : req.sample_value;
    temp     = req.sample_value[19] ? 8'd0 :
               (|req.sample_value[18:8]) ? 8'hFF : req.sample_value[7:0];
    duty_sum = {1'b0, st.duty} + {1'b0, cfg.duty_gain};
    ramp_inc = st.ramp_tally + 8'd1;
    ramp_sum = {1'b0, st.ramp_target} + 17'(bssc_pkg::RAMP_STEP);
  end

  // Next state for the request.
  always_comb begin
    st_next   = st;
    stop      = 1'b0;
    fault_set = 4'd0;
    adc       = bssc_pkg::ADC_NONE;
    fw        = 1'b0;
    unique case (req.req_type) inside
      bssc_pkg::REQ_START: begin
        st_next.mode = MODE_OPEN;
      end
      bssc_pkg::REQ_STOP, bssc_pkg::REQ_BREAK: begin
        stop = 1'b1;
      end
      bssc_pkg::REQ_PWM: begin
        if (st.mode == MODE_OPEN) begin
          if (!req.center_flag) begin
            // Alternate bus voltage and temperature conversions.
            if (st.adc_slot == 3'd0) begin
              adc = bssc_pkg::ADC_VBUS;
              st_next.adc_slot = 3'd1;
            end else if (st.adc_slot == 3'd1) begin
              adc = bssc_pkg::ADC_TEMP;
              st_next.adc_slot = 3'd0;
            end else begin
              st_next.adc_slot = 3'd0;
            end
            // Commutate in the direction of the speed reference.
            st_next.sense_leg = sense_of(st.step);
            if (st.speed_neg) begin
              st_next.step = (st.step <= 3'd1) ? 3'd6 : st.step - 3'd1;
            end else begin
              st_next.step = (st.step >= 3'd6) ? 3'd1 : st.step + 3'd1;
            end
            // Pole, revolution and ramp counting.
            if ({1'b0, st.pole_tally} + 9'd1 < {1'b0, cfg.pole_pairs}) begin
              st_next.pole_tally = st.pole_tally + 8'd1;
            end else begin
              st_next.pole_tally = 8'd0;
              if (st.rev_tally != 16'hFFFF) begin
                st_next.rev_tally = st.rev_tally + 16'd1;
              end
              if ({1'b0, ramp_inc} + 9'd1 >= {1'b0, cfg.revs_per_ramp}) begin
                st_next.ramp_tally = 8'd0;
                if (st.ramp_target < 16'(bssc_pkg::MIN_SPEED)) begin
                  st_next.ramp_target = ramp_sum[16] ? 16'hFFFF : ramp_sum[15:0];
                end else begin
                  st_next.mode = MODE_CLOSED;
                end
              end else begin
                st_next.ramp_tally = ramp_inc;
              end
            end
          end else if (st.sense_leg != 2'd0) begin
            // Current channel of the sense leg: codes follow temperature.
            adc = bssc_pkg::ADC_TEMP + 3'(st.sense_leg);
          end
        end else if (st.mode == MODE_CLOSED) begin
          stop = 1'b1;
        end
      end
      bssc_pkg::REQ_SYSTICK: begin
        // Round-robin ADC requests while idle.
        if (st.mode == MODE_IDLE) begin
          if (st.adc_slot <= 3'd3) begin
            adc = st.adc_slot + 3'd1;
            st_next.adc_slot = st.adc_slot + 3'd1;
          end else if (st.adc_slot == 3'd4) begin
            adc = bssc_pkg::ADC_CUR3;
            st_next.adc_slot = 3'd0;
          end else begin
            st_next.adc_slot = 3'd0;
          end
        end
        // Speed measurement window; rpm is four times the revolutions.
        if (st.window_tally < 8'(bssc_pkg::RPM_WINDOW)) begin
          st_next.window_tally = st.window_tally + 8'd1;
        end else begin
          st_next.rpm = (|st.rev_tally[15:14]) ? 16'hFFFF : {st.rev_tally[13:0], 2'b00};
          st_next.rev_tally = 16'd0;
          st_next.window_tally = 8'd0;
        end
      end
      bssc_pkg::REQ_CURRENT: begin
        if (mag > {1'b0, cfg.trip_current_ma}) begin
          fault_set = 4'b0100;
          stop = 1'b1;
        end else if (st.mode == MODE_OPEN) begin
          // Startup duty regulation from current magnitude.
          if (mag < {1'b0, cfg.min_start_current_ma}) begin
            st_next.duty = (duty_sum < 11'(bssc_pkg::PWM_MAX)) ? duty_sum[9:0] :
                           10'(bssc_pkg::PWM_MAX);
          end else if (mag > {1'b0, cfg.max_start_current_ma}) begin
            st_next.duty = (st.duty > cfg.duty_gain) ? st.duty - cfg.duty_gain : 10'd0;
            fw = 1'b1;
          end
        end
      end
      bssc_pkg::REQ_TEMP: begin
        if (temp > cfg.trip_temp_c) begin
          fault_set = 4'b1000;
          stop = 1'b1;
        end
      end
      bssc_pkg::REQ_VBUS: begin
        // Bus voltage is sampled but drives nothing here.
      end
      bssc_pkg::REQ_SPEED: begin
        // Only the sign is kept, and zero counts as positive.
        st_next.speed_neg = req.sample_value[19];
      end
      default: ;
    endcase

    // Stopping records the mode in the faults and idles at startup duty.
    if (stop) begin
      fw = 1'b1;
      st_next = cleared(cfg.startup_duty,
                        st.fault | fault_set | {2'b00, mode_code(st.mode)});
    end
  end

  // Result fields from the state after the request.
  always_comb begin
    res.run_mode         = mode_code(st_next.mode);
    res.commutation_step = st_next.step;
    res.driven_phase     = (st_next.mode != MODE_IDLE) ? phase_of(st_next.step) : 2'd0;
    res.leg_enable_mask  = (st_next.mode != MODE_IDLE) ? mask_of(st_next.step) : 3'd0;
    res.duty             = st_next.duty;
    res.sense_leg        = st_next.sense_leg;
    res.adc_request      = adc;
    res.fault_flags      = st_next.fault;
    res.measured_rpm     = st_next.rpm;
    res.ramp_rpm         = st_next.ramp_target;
    res.freewheel        = fw;
  end

endmodule

// ===== src/bldc_six_step_startup_controller.sv =====
// A request taken into the request register passes the core state update into the result register.
// Throughput: one request per cycle; while a finished result waits to be taken, the request
// register still takes one more request, and then the input stalls until the result drains.
// The combinational state update between those registers sets the rate.
// Reset (rst, synchronous) loads the default configuration, idles the motor and clears faults.
module bldc_six_step_startup_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wen,
  input  logic [2:0]    cfg_index,
  input  logic [18:0]   cfg_data,
  bssc_req_if.sink      req,
  bssc_res_if.source    res
);

  bssc_pkg::cfg_t cfg;
  bssc_pkg::req_t req_reg;
  bssc_pkg::res_t res_core;
  bssc_pkg::res_t res_reg;
  logic           req_valid;
  logic           res_valid;
  logic           advance;

  bssc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bssc_core u_core (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .cfg (cfg),
    .req (req_reg),
    .res (res_core)
  );

  // The held request completes when the result register is free or drained.
  assign advance   = req_valid && (!res_valid || res.ready);
  assign req.ready = !req_valid || advance;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_reg.req_type     <= req.req_type;
      req_reg.center_flag  <= req.center_flag;
      req_reg.sample_value <= req.sample_value;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= res_core;
    end
  end

  // Result channel drive.
  assign res.valid            = res_valid;
  assign res.run_mode         = res_reg.run_mode;
  assign res.commutation_step = res_reg.commutation_step;
  assign res.driven_phase     = res_reg.driven_phase;
  assign res.leg_enable_mask  = res_reg.leg_enable_mask;
  assign res.duty             = res_reg.duty;
  assign res.sense_leg        = res_reg.sense_leg;
  assign res.adc_request      = res_reg.adc_request;
  assign res.fault_flags      = res_reg.fault_flags;
  assign res.measured_rpm     = res_reg.measured_rpm;
  assign res.ramp_rpm         = res_reg.ramp_rpm;
  assign res.freewheel        = res_reg.freewheel;

endmodule
